FILE: rtl/stt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package stt_pkg;

  localparam int MAX_RES = 4;
  localparam int RES_IW  = $clog2(MAX_RES);
  localparam int CNT_W   = $clog2(MAX_RES + 1);
  localparam int Q_DEPTH = 4;

  // lexer modes
  localparam logic [2:0] M_IDLE    = 3'd0;
  localparam logic [2:0] M_SLASH   = 3'd1;
  localparam logic [2:0] M_COMMENT = 3'd2;
  localparam logic [2:0] M_WORD    = 3'd3;
  localparam logic [2:0] M_QUOTED  = 3'd4;
  localparam logic [2:0] M_ESC     = 3'd5;

  // event codes
  localparam logic [1:0] EV_CONT  = 2'd0;
  localparam logic [1:0] EV_START = 2'd1;
  localparam logic [1:0] EV_END   = 2'd2;

  // token kinds
  localparam logic [2:0] K_OPEN  = 3'd0;
  localparam logic [2:0] K_CLOSE = 3'd1;
  localparam logic [2:0] K_COLON = 3'd2;
  localparam logic [2:0] K_QUOTE = 3'd3;
  localparam logic [2:0] K_WORD  = 3'd4;

  // character codes
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_VT     = 8'h0B;
  localparam logic [7:0] CH_FF     = 8'h0C;
  localparam logic [7:0] CH_CR     = 8'h0D;

  typedef struct packed {
    logic [7:0] out_byte;
    logic [1:0] event_res;
    logic [2:0] token_kind;
    logic       last_of_run;
  } tok_res_t;

  // results of one source byte, res[0] first
  typedef struct packed {
    tok_res_t [MAX_RES-1:0] res;
    logic [CNT_W-1:0]       cnt;
  } tok_bundle_t;

endpackage

`default_nettype wire

FILE: rtl/scene_text_tokenizer.sv
`timescale 1ns / 1ps
`default_nettype none

// scene text tokenizer: source bytes in, token events out
// input stream s_*: one source byte per item, s_tlast on the final byte of a source
// output stream m_*: one token event per item, m_tlast on the last event of a byte
// events are token start with byte, continue with byte, or token end (byte zero)
// a source byte yields zero to four events; bytes with none produce no output
// an accepted byte's results go into the queue and on to the registered output stage
// throughput: one byte per cycle while each byte yields at most one event and
// m_tready is high; the output side sends one event per cycle while m_tready is
// high, so a byte with n events holds it until all are sent
// a queue of QDEPTH byte results sits between lexer and output serializer
// reset clears lexer mode to idle, empties the queue and drops m_tvalid
// when the receiver stalls, the output item holds, the queue fills,
// and s_tready falls once QDEPTH byte results are waiting

module scene_text_tokenizer #(
  parameter int QDEPTH = stt_pkg::Q_DEPTH
) (
  input  wire        clk,
  input  wire        rst,
  input  wire        s_tvalid,
  output logic       s_tready,
  input  wire  [7:0] s_tdata,   // [7:0] in_byte
  input  wire        s_tlast,   // end_of_input
  output logic       m_tvalid,
  input  wire        m_tready,
  output logic [7:0] m_tdata,   // [7:0] out_byte
  output logic [7:0] m_tuser,   // [1:0] event_res, [4:2] token_kind
  output logic       m_tlast    // last_of_run
);
  import stt_pkg::*;

  localparam int QCW = $clog2(QDEPTH + 1);

  logic        push;
  logic        q_full;
  logic        q_empty;
  logic        pop;
  logic [QCW-1:0] q_cnt;
  logic [2:0]  lex_mode;
  tok_bundle_t in_bnd;
  tok_bundle_t head;
  tok_res_t    m_res;

  stt_front u_front (
    .clk      (clk),
    .rst      (rst),
    .s_valid  (s_tvalid),
    .s_byte   (s_tdata),
    .s_last   (s_tlast),
    .s_ready  (s_tready),
    .q_full   (q_full),
    .push     (push),
    .bundle   (in_bnd),
    .lex_mode (lex_mode)
  );

  stt_fifo #(
    .DEPTH (QDEPTH)
  ) u_fifo (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .wr_data (in_bnd),
    .pop     (pop),
    .rd_data (head),
    .full    (q_full),
    .empty   (q_empty),
    .count   (q_cnt)
  );

  stt_back u_back (
    .clk     (clk),
    .rst     (rst),
    .head    (head),
    .q_empty (q_empty),
    .pop     (pop),
    .m_valid (m_tvalid),
    .m_ready (m_tready),
    .m_res   (m_res)
  );

  assign m_tdata = m_res.out_byte;
  assign m_tuser = {3'b000, m_res.token_kind, m_res.event_res};
  assign m_tlast = m_res.last_of_run;

  a_qcnt: assert property (@(posedge clk) disable iff (rst)
    q_cnt <= QCW'(QDEPTH))
    else $error("queue count beyond depth");

  a_eoi_idle: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && s_tlast |=> lex_mode == M_IDLE)
    else $error("lexer not idle after end of source");

  a_end_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[1:0] == EV_END |-> m_tdata == 8'h00)
    else $error("token end event carries a byte");

  a_push_room: assert property (@(posedge clk) disable iff (rst)
    push |-> !q_full)
    else $error("push into full queue");

endmodule

`default_nettype wire

FILE: rtl/stt_front.sv
`timescale 1ns / 1ps
`default_nettype none

module stt_front (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 s_valid,
  input  wire  [7:0]          s_byte,
  input  wire                 s_last,
  output logic                s_ready,
  input  wire                 q_full,
  output logic                push,
  output stt_pkg::tok_bundle_t bundle,
  output logic [2:0]          lex_mode
);
  import stt_pkg::*;

  typedef struct packed {
    tok_bundle_t bnd;
    logic [2:0]  mode;
    logic        qs;
  } work_t;

  logic       qsingle;
  logic       fire;
  logic [7:0] qch;
  logic [CNT_W-1:0] last_idx;
  work_t      w;

  function automatic logic is_space(logic [7:0] c);
    return c == CH_SPACE || c == CH_TAB || c == CH_NL || c == CH_VT || c == CH_FF
        || c == CH_CR;
  endfunction

  function automatic work_t emit(work_t w_in, logic [7:0] b, logic [1:0] ev,
                                 logic [2:0] k);
    work_t r;
    r = w_in;
    if (w_in.bnd.cnt < CNT_W'(MAX_RES)) begin
      r.bnd.res[w_in.bnd.cnt[RES_IW-1:0]].out_byte    = b;
      r.bnd.res[w_in.bnd.cnt[RES_IW-1:0]].event_res   = ev;
      r.bnd.res[w_in.bnd.cnt[RES_IW-1:0]].token_kind  = k;
      r.bnd.res[w_in.bnd.cnt[RES_IW-1:0]].last_of_run = 1'b0;
      r.bnd.cnt = w_in.bnd.cnt + CNT_W'(1);
    end
    return r;
  endfunction

  function automatic work_t single_token(work_t w_in, logic [7:0] c, logic [2:0] k);
    work_t r;
    r = emit(w_in, c, EV_START, k);
    r = emit(r, 8'h00, EV_END, k);
    return r;
  endfunction

  function automatic work_t idle_byte(work_t w_in, logic [7:0] c);
    work_t r;
    r = w_in;
    if (is_space(c) || c == CH_COMMA) begin
      r = w_in;
    end else if (c == CH_SLASH) begin
      r.mode = M_SLASH;
    end else if (c == CH_HASH) begin
      r.mode = M_COMMENT;
    end else if (c == CH_LBRACE) begin
      r = single_token(r, c, K_OPEN);
    end else if (c == CH_RBRACE) begin
      r = single_token(r, c, K_CLOSE);
    end else if (c == CH_COLON) begin
      r = single_token(r, c, K_COLON);
    end else if (c == CH_DQUOTE || c == CH_SQUOTE) begin
      r.qs   = (c == CH_SQUOTE);
      r      = emit(r, CH_DQUOTE, EV_START, K_QUOTE);
      r.mode = M_QUOTED;
    end else begin
      r      = emit(r, c, EV_START, K_WORD);
      r.mode = M_WORD;
    end
    return r;
  endfunction

  function automatic work_t word_byte(work_t w_in, logic [7:0] c);
    work_t r;
    r = w_in;
    if (is_space(c) || c == CH_LBRACE || c == CH_RBRACE || c == CH_COLON
        || c == CH_HASH) begin
      r      = emit(r, 8'h00, EV_END, K_WORD);
      r.mode = M_IDLE;
      r      = idle_byte(r, c);
    end else if (c == CH_COMMA) begin
      r      = emit(r, 8'h00, EV_END, K_WORD);
      r.mode = M_IDLE;
    end else begin
      r = emit(r, c, EV_CONT, K_WORD);
    end
    return r;
  endfunction

  always_comb begin
    w      = '0;
    w.mode = lex_mode;
    w.qs   = qsingle;
    qch    = qsingle ? CH_SQUOTE : CH_DQUOTE;
    unique case (lex_mode)
      M_SLASH: begin
        if (s_byte == CH_SLASH) begin
          w.mode = M_COMMENT;
        end else begin
          w      = emit(w, CH_SLASH, EV_START, K_WORD);
          w.mode = M_WORD;
          w      = word_byte(w, s_byte);
        end
      end
      M_COMMENT: begin
        if (s_byte == CH_NL) w.mode = M_IDLE;
      end
      M_WORD: begin
        w = word_byte(w, s_byte);
      end
      M_QUOTED: begin
        if (s_byte == CH_BSLASH && !s_last) begin
          w.mode = M_ESC;
        end else if (s_byte == qch) begin
          w      = emit(w, CH_DQUOTE, EV_CONT, K_QUOTE);
          w      = emit(w, 8'h00, EV_END, K_QUOTE);
          w.mode = M_IDLE;
        end else begin
          w = emit(w, s_byte, EV_CONT, K_QUOTE);
        end
      end
      M_ESC: begin
        w      = emit(w, s_byte, EV_CONT, K_QUOTE);
        w.mode = M_QUOTED;
      end
      M_IDLE: begin
        w = idle_byte(w, s_byte);
      end
      default: begin
        w.mode = M_IDLE;
        w      = idle_byte(w, s_byte);
      end
    endcase

    // end of source closes whatever is open
    if (s_last) begin
      if (w.mode == M_SLASH) begin
        w = single_token(w, CH_SLASH, K_WORD);
      end else if (w.mode == M_WORD) begin
        w = emit(w, 8'h00, EV_END, K_WORD);
      end else if (w.mode == M_QUOTED || w.mode == M_ESC) begin
        w = emit(w, CH_DQUOTE, EV_CONT, K_QUOTE);
        w = emit(w, 8'h00, EV_END, K_QUOTE);
      end
      w.mode = M_IDLE;
      w.qs   = 1'b0;
    end

    last_idx = w.bnd.cnt - CNT_W'(1);
    if (w.bnd.cnt != '0) w.bnd.res[last_idx[RES_IW-1:0]].last_of_run = 1'b1;
  end

  assign s_ready = !q_full;
  assign fire    = s_valid && s_ready;
  assign push    = fire && (w.bnd.cnt != '0);
  assign bundle  = w.bnd;

  always_ff @(posedge clk) begin
    if (rst) begin
      lex_mode <= M_IDLE;
      qsingle  <= 1'b0;
    end else if (fire) begin
      lex_mode <= w.mode;
      qsingle  <= w.qs;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/stt_fifo.sv
`timescale 1ns / 1ps
`default_nettype none

module stt_fifo #(
  parameter int DEPTH = stt_pkg::Q_DEPTH
) (
  input  wire                            clk,
  input  wire                            rst,
  input  wire                            push,
  input  wire stt_pkg::tok_bundle_t      wr_data,
  input  wire                            pop,
  output stt_pkg::tok_bundle_t           rd_data,
  output logic                           full,
  output logic                           empty,
  output logic [$clog2(DEPTH+1)-1:0]     count
);
  import stt_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  tok_bundle_t   mem [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic          do_push;
  logic          do_pop;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + AW'(1);
      if (do_pop)  rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + AW'(1);
      if (do_push && !do_pop)      count <= count + CW'(1);
      else if (do_pop && !do_push) count <= count - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem[wr_ptr] <= wr_data;
  end

endmodule

`default_nettype wire

FILE: rtl/stt_back.sv
`timescale 1ns / 1ps
`default_nettype none

module stt_back (
  input  wire                  clk,
  input  wire                  rst,
  input  wire stt_pkg::tok_bundle_t head,
  input  wire                  q_empty,
  output logic                 pop,
  output logic                 m_valid,
  input  wire                  m_ready,
  output stt_pkg::tok_res_t    m_res
);
  import stt_pkg::*;

  logic [RES_IW-1:0] idx;
  logic              load;
  logic              take;
  logic              cur_last;
  tok_res_t          cur;

  always_comb begin
    load     = !m_valid || m_ready;
    take     = load && !q_empty;
    cur      = head.res[idx];
    cur_last = (CNT_W'(idx) + CNT_W'(1)) == head.cnt;
    pop      = take && cur_last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid <= 1'b0;
      idx     <= '0;
    end else begin
      if (load) m_valid <= !q_empty;
      if (take) idx <= cur_last ? '0 : idx + RES_IW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (take) m_res <= cur;
  end

endmodule

`default_nettype wire

FILE: sim/scene_text_tokenizer_tb.sv
`timescale 1ns / 1ps

module scene_text_tokenizer_tb;
  import stt_pkg::*;

  typedef struct packed {
    logic [7:0] b;
    logic       eoi;
  } source_item_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       s_tvalid = 1'b0;
  logic       s_tready;
  logic [7:0] s_tdata = 8'h00;   // [7:0] in_byte
  logic       s_tlast = 1'b0;    // end_of_input
  logic       m_tvalid;
  logic       m_tready = 1'b0;
  logic [7:0] m_tdata;           // [7:0] out_byte
  logic [7:0] m_tuser;           // [1:0] event_res, [4:2] token_kind
  logic       m_tlast;           // last_of_run

  scene_text_tokenizer i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  source_item_t source_bytes[$];
  tok_res_t     pending_events[$];

  logic [2:0] lex_mode = M_IDLE;
  logic       quote_sq = 1'b0;
  tok_res_t   byte_events[MAX_RES];
  int         byte_event_n;

  int errors = 0;
  int bytes_taken = 0;
  int sources_closed = 0;
  int events_checked = 0;
  int busiest_byte = 0;

  task automatic flag_error(input string msg);
    if (errors < 10) begin
      $display("mismatch: %s", msg);
    end
    errors++;
  endtask

  function automatic bit is_blank(input logic [7:0] c);
    return c == CH_SPACE || c == CH_TAB || c == CH_NL || c == CH_VT || c == CH_FF ||
           c == CH_CR;
  endfunction

  function void add_event(input logic [7:0] b, input logic [1:0] ev, input logic [2:0] kind);
    if (byte_event_n < MAX_RES) begin
      byte_events[byte_event_n].out_byte    = b;
      byte_events[byte_event_n].event_res   = ev;
      byte_events[byte_event_n].token_kind  = kind;
      byte_events[byte_event_n].last_of_run = 1'b0;
      byte_event_n++;
    end
  endfunction

  function void add_single(input logic [7:0] c, input logic [2:0] kind);
    add_event(c, EV_START, kind);
    add_event(8'h00, EV_END, kind);
  endfunction

  function void close_quote();
    add_event(CH_DQUOTE, EV_CONT, K_QUOTE);
    add_event(8'h00, EV_END, K_QUOTE);
    lex_mode = M_IDLE;
  endfunction

  function void lex_idle(input logic [7:0] c);
    if (is_blank(c) || c == CH_COMMA) begin
      return;
    end
    if (c == CH_SLASH) begin
      lex_mode = M_SLASH;
    end else if (c == CH_HASH) begin
      lex_mode = M_COMMENT;
    end else if (c == CH_LBRACE) begin
      add_single(c, K_OPEN);
    end else if (c == CH_RBRACE) begin
      add_single(c, K_CLOSE);
    end else if (c == CH_COLON) begin
      add_single(c, K_COLON);
    end else if (c == CH_DQUOTE || c == CH_SQUOTE) begin
      quote_sq = (c == CH_SQUOTE);
      add_event(CH_DQUOTE, EV_START, K_QUOTE);
      lex_mode = M_QUOTED;
    end else begin
      add_event(c, EV_START, K_WORD);
      lex_mode = M_WORD;
    end
  endfunction

  function void lex_word(input logic [7:0] c);
    if (is_blank(c) || c == CH_LBRACE || c == CH_RBRACE || c == CH_COLON || c == CH_HASH) begin
      add_event(8'h00, EV_END, K_WORD);
      lex_mode = M_IDLE;
      lex_idle(c);
    end else if (c == CH_COMMA) begin
      add_event(8'h00, EV_END, K_WORD);
      lex_mode = M_IDLE;
    end else begin
      add_event(c, EV_CONT, K_WORD);
    end
  endfunction

  // works out the token events of one accepted source byte
  function void lex_byte(input logic [7:0] c, input logic eoi);
    logic [7:0] close_ch;
    tok_res_t   r;
    byte_event_n = 0;
    close_ch = quote_sq ? CH_SQUOTE : CH_DQUOTE;
    case (lex_mode)
      M_SLASH: begin
        if (c == CH_SLASH) begin
          lex_mode = M_COMMENT;
        end else begin
          add_event(CH_SLASH, EV_START, K_WORD);
          lex_mode = M_WORD;
          lex_word(c);
        end
      end
      M_COMMENT: begin
        if (c == CH_NL) begin
          lex_mode = M_IDLE;
        end
      end
      M_WORD: begin
        lex_word(c);
      end
      M_QUOTED: begin
        if (c == CH_BSLASH && !eoi) begin
          lex_mode = M_ESC;
        end else if (c == close_ch) begin
          close_quote();
        end else begin
          add_event(c, EV_CONT, K_QUOTE);
        end
      end
      M_ESC: begin
        add_event(c, EV_CONT, K_QUOTE);
        lex_mode = M_QUOTED;
      end
      default: begin
        lex_mode = M_IDLE;
        lex_idle(c);
      end
    endcase
    if (eoi) begin
      if (lex_mode == M_SLASH) begin
        add_single(CH_SLASH, K_WORD);
      end else if (lex_mode == M_WORD) begin
        add_event(8'h00, EV_END, K_WORD);
      end else if (lex_mode == M_QUOTED || lex_mode == M_ESC) begin
        close_quote();
      end
      lex_mode = M_IDLE;
      quote_sq = 1'b0;
    end
    for (int i = 0; i < byte_event_n; i++) begin
      r = byte_events[i];
      r.last_of_run = (i == byte_event_n - 1);
      pending_events.insert(pending_events.size(), r);
    end
    if (byte_event_n > busiest_byte) begin
      busiest_byte = byte_event_n;
    end
  endfunction

  task automatic push_src(input logic [7:0] b, input logic eoi = 1'b0);
    source_item_t it;
    it.b = b;
    it.eoi = eoi;
    source_bytes.insert(source_bytes.size(), it);
  endtask

  task automatic end_source();
    source_bytes[source_bytes.size() - 1].eoi = 1'b1;
  endtask

  // sender: bursts with gaps
  int burst_left = 1;
  int gap_left = 0;
  source_item_t next_item;

  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        lex_byte(s_tdata, s_tlast);
        bytes_taken++;
        if (s_tlast) begin
          sources_closed++;
        end
      end
      if (s_tvalid && !s_tready) begin
        // hold the offered item
      end else if (gap_left > 0) begin
        gap_left--;
        s_tvalid <= 1'b0;
      end else if (source_bytes.size() > 0) begin
        next_item = source_bytes.pop_front();
        s_tvalid <= 1'b1;
        s_tdata  <= next_item.b;
        s_tlast  <= next_item.eoi;
        if (burst_left > 1) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 24);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        end
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // receiver: stall pattern is drawn anew whenever its countdown runs out
  int stall_mode = 0;
  int stall_left = 0;
  logic [1:0] rdy_phase = 2'd0;

  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (stall_left == 0) begin
        stall_mode = $urandom_range(0, 3);
        stall_left = $urandom_range(20, 80);
      end else begin
        stall_left--;
      end
      case (stall_mode)
        0: m_tready <= 1'b1;
        1: m_tready <= 1'($urandom_range(0, 1));
        2: m_tready <= ($urandom_range(0, 4) == 0);
        default: m_tready <= (rdy_phase != 2'd3);
      endcase
      rdy_phase <= rdy_phase + 2'd1;
    end
  end

  tok_res_t got_event;
  tok_res_t want_event;

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      got_event.out_byte    = m_tdata;
      got_event.event_res   = m_tuser[1:0];
      got_event.token_kind  = m_tuser[4:2];
      got_event.last_of_run = m_tlast;
      events_checked++;
      if (pending_events.size() == 0) begin
        flag_error($sformatf("unexpected event byte=%h ev=%0d kind=%0d last=%0b",
                             got_event.out_byte, got_event.event_res,
                             got_event.token_kind, got_event.last_of_run));
      end else begin
        want_event = pending_events.pop_front();
        if (got_event !== want_event) begin
          flag_error($sformatf(
            "expected byte=%h ev=%0d kind=%0d last=%0b, got byte=%h ev=%0d kind=%0d last=%0b",
            want_event.out_byte, want_event.event_res, want_event.token_kind,
            want_event.last_of_run, got_event.out_byte, got_event.event_res,
            got_event.token_kind, got_event.last_of_run));
        end
      end
    end
  end

  initial begin
    int n;
    int k;
    logic [7:0] qc;

    // braces, colon, words with slashes and quotes inside
    push_src(CH_LBRACE);
    push_src(8'h61);
    push_src(CH_SLASH);
    push_src(CH_SLASH);
    push_src(CH_SQUOTE);
    push_src(CH_COLON);
    push_src(CH_COMMA);
    push_src(8'hFF);
    push_src(CH_COMMA);
    // lone slash followed by a brace gives four events
    push_src(CH_SLASH);
    push_src(CH_LBRACE);
    push_src(CH_SLASH);
    push_src(8'h78);
    push_src(CH_RBRACE);
    // single-quoted string with escape, zero byte and a double quote inside
    push_src(CH_SQUOTE);
    push_src(CH_DQUOTE);
    push_src(CH_BSLASH);
    push_src(CH_SQUOTE);
    push_src(8'h00);
    push_src(CH_SQUOTE);
    // comments
    push_src(CH_HASH);
    push_src(8'hFF);
    push_src(CH_NL);
    push_src(CH_SLASH);
    push_src(CH_SLASH);
    push_src(CH_NL);
    // end of input closing a string on a backslash, a lone slash, a word
    push_src(CH_DQUOTE);
    push_src(CH_BSLASH, 1'b1);
    push_src(CH_SLASH, 1'b1);
    push_src(8'h71, 1'b1);

    n = source_bytes.size();
    while (source_bytes.size() - n < 100) begin
      case ($urandom_range(0, 9))
        0, 1: begin
          case ($urandom_range(0, 5))
            0: push_src(CH_SPACE);
            1: push_src(CH_TAB);
            2: push_src(CH_NL);
            3: push_src(CH_VT);
            4: push_src(CH_FF);
            default: push_src(CH_CR);
          endcase
        end
        2, 3: begin
          k = $urandom_range(1, 5);
          repeat (k) begin
            if ($urandom_range(0, 7) == 0) begin
              push_src(8'($urandom_range(0, 255)));
            end else begin
              push_src(8'($urandom_range(8'h61, 8'h7A)));
            end
          end
        end
        4: begin
          qc = $urandom_range(0, 1) ? CH_DQUOTE : CH_SQUOTE;
          push_src(qc);
          k = $urandom_range(0, 5);
          repeat (k) begin
            if ($urandom_range(0, 3) == 0) begin
              push_src(CH_BSLASH);
              push_src(8'($urandom_range(0, 255)));
            end else begin
              push_src(8'($urandom_range(8'h20, 8'h7E)));
            end
          end
          if ($urandom_range(0, 4) != 0) begin
            push_src(qc);
          end
        end
        5: begin
          if ($urandom_range(0, 1)) begin
            push_src(CH_HASH);
          end else begin
            push_src(CH_SLASH);
            push_src(CH_SLASH);
          end
          k = $urandom_range(0, 4);
          repeat (k) push_src(8'($urandom_range(8'h20, 8'h7E)));
          push_src(CH_NL);
        end
        6: begin
          case ($urandom_range(0, 2))
            0: push_src(CH_LBRACE);
            1: push_src(CH_RBRACE);
            default: push_src(CH_COLON);
          endcase
        end
        7: push_src(CH_COMMA);
        8: push_src(CH_SLASH);
        default: push_src(8'($urandom_range(0, 255)));
      endcase
      if ($urandom_range(0, 9) == 0) begin
        end_source();
      end
    end
    end_source();

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    while (source_bytes.size() != 0 || s_tvalid) @(posedge clk);
    while (pending_events.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (pending_events.size() != 0) begin
      flag_error($sformatf("%0d events never arrived", pending_events.size()));
    end

    $display("%0d source bytes in %0d sources, %0d token events checked",
             bytes_taken, sources_closed, events_checked);
    $display("most events from one byte: %0d, errors: %0d", busiest_byte, errors);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #400000;
    $display("TEST FAILED");
    $finish;
  end

endmodule

FILE: sim.f
rtl/stt_pkg.sv
rtl/stt_front.sv
rtl/stt_fifo.sv
rtl/stt_back.sv
rtl/scene_text_tokenizer.sv
sim/scene_text_tokenizer_tb.sv
